/* design/eeb_pkg.sv */
package eeb_pkg;

	// field widths
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned WADDR_W  = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DEV_W    = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PHASE_W  = 6;
	localparam int unsigned BITCNT_W = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ACK   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BUS_LOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_BYTE_ADDR = 2'd2;

	// configuration reset values
	localparam logic [DEV_W-1:0]  DEVICE_ADDR_RST = 7'd80;
	localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

	// byte slots: phase is slot * 4 + sub-phase
	localparam logic [2:0] SLOT_DEVW = 3'd1;
	localparam logic [2:0] SLOT_AHI  = 3'd2;
	localparam logic [2:0] SLOT_ALO  = 3'd3;
	localparam logic [2:0] SLOT_DATA = 3'd4;
	localparam logic [2:0] SLOT_DEVR = 3'd5;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE  = 6'd0;
	localparam logic [PHASE_W-1:0] PH_S1P   = 6'd32;
	localparam logic [PHASE_W-1:0] PH_S1A   = 6'd33;
	localparam logic [PHASE_W-1:0] PH_S1B   = 6'd34;
	localparam logic [PHASE_W-1:0] PH_S2P   = 6'd36;
	localparam logic [PHASE_W-1:0] PH_S2A   = 6'd37;
	localparam logic [PHASE_W-1:0] PH_S2B   = 6'd38;
	localparam logic [PHASE_W-1:0] PH_READ  = 6'd40;
	localparam logic [PHASE_W-1:0] PH_NACKL = 6'd41;
	localparam logic [PHASE_W-1:0] PH_NACKH = 6'd42;
	localparam logic [PHASE_W-1:0] PH_SLOT_LO = 6'd4;
	localparam logic [PHASE_W-1:0] PH_SLOT_HI = 6'd24;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [WADDR_W-1:0] word_addr;
		logic [BYTE_W-1:0]  write_data;
		logic               sda_in;
	} item_t;

	typedef struct packed {
		logic                scl_out;
		logic                sda_out;
		logic                sda_drive;
		logic                busy_res;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   read_data;
	} result_t;

	typedef struct packed {
		logic [DEV_W-1:0]  device_addr;
		logic [BYTE_W-1:0] ack_timeout;
		logic              two_byte_addr;
	} cfg_t;

endpackage

/* design/eeb_item_if.sv */
interface eeb_item_if import eeb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [WADDR_W-1:0] word_addr;
	logic [BYTE_W-1:0]  write_data;
	logic               sda_in;

	modport source (output valid, req_type, word_addr, write_data, sda_in, input ready);
	modport sink (input valid, req_type, word_addr, write_data, sda_in, output ready);
endinterface

/* design/eeb_result_if.sv */
interface eeb_result_if import eeb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                scl_out;
	logic                sda_out;
	logic                sda_drive;
	logic                busy_res;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   read_data;

	modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res, status,
		read_data, input ready);
	modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res, status,
		read_data, output ready);
endinterface

/* design/eeb_cfg_if.sv */
interface eeb_cfg_if import eeb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/eeb_cfg.sv */
module eeb_cfg import eeb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_addr   <= DEVICE_ADDR_RST;
			cfg_q.ack_timeout   <= ACK_TIMEOUT_RST;
			cfg_q.two_byte_addr <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DEVICE_ADDR:   cfg_q.device_addr   <= wr_data[DEV_W-1:0];
				CFG_ACK_TIMEOUT:   cfg_q.ack_timeout   <= wr_data[BYTE_W-1:0];
				CFG_TWO_BYTE_ADDR: cfg_q.two_byte_addr <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/eeb_engine.sv */
module eeb_engine import eeb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [BITCNT_W-1:0] bit_count_q, bit_count_d;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic [BYTE_W-1:0]   wait_q, wait_d;
	logic [WADDR_W-1:0]  addr_q, addr_d;
	logic [BYTE_W-1:0]   data_q, data_d;
	logic                is_read_q, is_read_d;
	logic [BYTE_W-1:0]   read_result_q, read_result_d;
	logic [STATUS_W-1:0] last_status_q, last_status_d;

	logic       in_slot, in_stop, is_req, done;
	logic [2:0] slot;
	logic [1:0] sub;
	logic       scl, sdo, drv;

	assign in_slot = (phase_q >= PH_SLOT_LO) && (phase_q < PH_SLOT_HI);
	assign in_stop = (phase_q[5:4] == 2'b11);
	assign slot    = phase_q[4:2];
	assign sub     = phase_q[1:0];
	assign is_req  = (item.req_type == REQ_WRITE) || (item.req_type == REQ_READ);

	// bus levels driven during this tick, from the current phase
	always_comb begin
		scl = 1'b1;
		sdo = 1'b1;
		drv = 1'b1;
		priority if (in_slot) begin
			unique case (sub)
				2'd0: begin
					scl = bit_count_q[0];
					sdo = shift_q[BYTE_W-1];
				end
				2'd1: begin
					scl = 1'b0;
					drv = 1'b0;
				end
				2'd2: drv = 1'b0;
				default: ;
			endcase
		end else if (in_stop) begin
			unique case (sub)
				2'd0: begin
					scl = 1'b0;
					sdo = 1'b0;
				end
				2'd1: sdo = 1'b0;
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				PH_S1P, PH_S2P, PH_NACKL: scl = 1'b0;
				PH_S1B, PH_S2B: sdo = 1'b0;
				PH_READ: begin
					scl = bit_count_q[0];
					drv = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// next state for one tick or request
	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		shift_d       = shift_q;
		wait_d        = wait_q;
		addr_d        = addr_q;
		data_d        = data_q;
		is_read_d     = is_read_q;
		read_result_d = read_result_q;
		last_status_d = last_status_q;
		done          = 1'b0;
		priority if (is_req && (phase_q != PH_IDLE)) begin
			// rejected request, nothing changes
		end else if (is_req) begin
			addr_d      = item.word_addr;
			data_d      = item.write_data;
			is_read_d   = (item.req_type == REQ_READ);
			bit_count_d = '0;
			wait_d      = '0;
			phase_d     = PH_S1P;
		end else if (phase_q == PH_IDLE) begin
			// idle tick
		end else if (in_slot) begin
			unique case (sub)
				// data bit, two ticks per bit
				2'd0: begin
					if (bit_count_q[0])
						shift_d = {shift_q[BYTE_W-2:0], 1'b0};
					if (bit_count_q == '1) begin
						phase_d     = {1'b0, slot, 2'd1};
						bit_count_d = '0;
					end else begin
						bit_count_d = bit_count_q + 1'b1;
					end
				end
				// release sda for the ack
				2'd1: begin
					wait_d  = '0;
					phase_d = {1'b0, slot, 2'd2};
				end
				// ack sample with timeout
				2'd2: begin
					if (!item.sda_in) begin
						bit_count_d = '0;
						unique case (slot)
							SLOT_DEVW: begin
								if (cfg.two_byte_addr) begin
									phase_d = {1'b0, SLOT_AHI, 2'd0};
									shift_d = addr_q[WADDR_W-1:BYTE_W];
								end else begin
									phase_d = {1'b0, SLOT_ALO, 2'd0};
									shift_d = addr_q[BYTE_W-1:0];
								end
							end
							SLOT_AHI: begin
								phase_d = {1'b0, SLOT_ALO, 2'd0};
								shift_d = addr_q[BYTE_W-1:0];
							end
							SLOT_ALO: begin
								if (is_read_q) begin
									phase_d     = PH_S2P;
									bit_count_d = bit_count_q;
								end else begin
									phase_d = {1'b0, SLOT_DATA, 2'd0};
									shift_d = data_q;
								end
							end
							SLOT_DEVR: begin
								phase_d = PH_READ;
								shift_d = '0;
							end
							default: begin
								phase_d     = {2'b11, ST_OK, 2'd0};
								bit_count_d = bit_count_q;
							end
						endcase
					end else if (wait_q >= cfg.ack_timeout) begin
						phase_d = {2'b11, ST_NO_ACK, 2'd0};
					end else begin
						wait_d = wait_q + 1'b1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end else if (in_stop) begin
			unique case (sub)
				2'd0, 2'd1: phase_d = phase_q + 1'b1;
				2'd2: begin
					last_status_d = phase_q[3:2];
					if ((phase_q[3:2] == ST_OK) && is_read_q)
						read_result_d = shift_q;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end else begin
			unique case (phase_q)
				PH_S1P, PH_S2P, PH_NACKL: phase_d = phase_q + 1'b1;
				PH_S1A, PH_S2A: begin
					if (!item.sda_in) phase_d = {2'b11, ST_BUS_LOW, 2'd0};
					else phase_d = phase_q + 1'b1;
				end
				PH_S1B: begin
					if (item.sda_in) begin
						phase_d = {2'b11, ST_BUS_LOW, 2'd0};
					end else begin
						phase_d     = {1'b0, SLOT_DEVW, 2'd0};
						shift_d     = {cfg.device_addr, 1'b0};
						bit_count_d = '0;
					end
				end
				PH_S2B: begin
					if (item.sda_in) begin
						phase_d = {2'b11, ST_BUS_LOW, 2'd0};
					end else begin
						phase_d     = {1'b0, SLOT_DEVR, 2'd0};
						shift_d     = {cfg.device_addr, 1'b1};
						bit_count_d = '0;
					end
				end
				PH_READ: begin
					if (bit_count_q[0])
						shift_d = {shift_q[BYTE_W-2:0], item.sda_in};
					if (bit_count_q == '1) begin
						phase_d     = PH_NACKL;
						bit_count_d = '0;
					end else begin
						bit_count_d = bit_count_q + 1'b1;
					end
				end
				PH_NACKH: phase_d = {2'b11, ST_OK, 2'd0};
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// state registers, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			shift_q       <= '0;
			wait_q        <= '0;
			addr_q        <= '0;
			data_q        <= '0;
			is_read_q     <= 1'b0;
			read_result_q <= '0;
			last_status_q <= ST_OK;
		end else if (step_en) begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			shift_q       <= shift_d;
			wait_q        <= wait_d;
			addr_q        <= addr_d;
			data_q        <= data_d;
			is_read_q     <= is_read_d;
			read_result_q <= read_result_d;
			last_status_q <= last_status_d;
		end
	end

	// result of this tick
	always_comb begin
		result.scl_out   = scl;
		result.sda_out   = sdo;
		result.sda_drive = drv;
		result.busy_res  = (phase_d != PH_IDLE);
		result.done_res  = done;
		result.status    = (is_req && (phase_q != PH_IDLE)) ? ST_REJECTED : last_status_d;
		result.read_data = read_result_d;
	end

endmodule

/* design/i2c_eeprom_byte_master.sv */
// Single-byte EEPROM master for I2C, stepped by one transaction per bus half-phase: a
// phase tick carries the sampled SDA level and returns the SCL/SDA levels to drive, and a
// write or read request starts a bus transfer, or is rejected while one is running. The block
// takes one transaction every clock cycle while results are taken; a transaction waits in
// the input register, and its state update and result are registered together into the
// result register that drives the output. While a result waits to be taken, one more
// transaction is held in the input register and then the input stalls until the result
// is taken. Configuration writes are taken at any time on their own channel and should be
// issued only while no transfer is in progress.
module i2c_eeprom_byte_master import eeb_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	eeb_item_if.sink     items,
	eeb_result_if.source results,
	eeb_cfg_if.sink      cfg
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t step_res;
	cfg_t    cfg_regs;
	logic    adv, step_en;

	assign adv         = !valid_s2 || results.ready;
	assign step_en     = valid_s1 && adv;
	assign items.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	eeb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.req_type   <= items.req_type;
			item_s1.word_addr  <= items.word_addr;
			item_s1.write_data <= items.write_data;
			item_s1.sda_in     <= items.sda_in;
		end
	end

	eeb_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg_regs),
		.result  (step_res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= step_res;
		end
	end

	assign results.valid     = valid_s2;
	assign results.scl_out   = res_s2.scl_out;
	assign results.sda_out   = res_s2.sda_out;
	assign results.sda_drive = res_s2.sda_drive;
	assign results.busy_res  = res_s2.busy_res;
	assign results.done_res  = res_s2.done_res;
	assign results.status    = res_s2.status;
	assign results.read_data = res_s2.read_data;

endmodule

/* verif/i2c_eeprom_byte_master_tb.sv */
module i2c_eeprom_byte_master_tb import eeb_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PHASE_W-1:0]  PH_STOP     = 6'd48;
	localparam logic [REQ_W-1:0]    REQ_SPARE   = 2'd3;
	localparam logic [1:0]          SUB_BIT     = 2'd0;
	localparam logic [1:0]          SUB_RELEASE = 2'd1;
	localparam logic [1:0]          SUB_ACK     = 2'd2;
	localparam logic [1:0]          STOP_LOW    = 2'd0;
	localparam logic [1:0]          STOP_SCL    = 2'd1;
	localparam logic [1:0]          STOP_DONE   = 2'd2;
	localparam logic [BITCNT_W-1:0] BIT_LAST    = 4'd15;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ITEMS    = 180;

	// bus sequencer prediction and result checking
	class i2c_txn_scoreboard;
		logic [DEV_W-1:0]    dev_addr;
		logic [BYTE_W-1:0]   ack_limit;
		logic                two_byte;
		logic [PHASE_W-1:0]  phase;
		logic [BITCNT_W-1:0] bit_cnt;
		logic [BYTE_W-1:0]   shreg;
		logic [BYTE_W-1:0]   wait_cnt;
		logic [WADDR_W-1:0]  addr_q;
		logic [BYTE_W-1:0]   data_q;
		logic                rd_q;
		logic [BYTE_W-1:0]   rd_byte;
		logic [STATUS_W-1:0] last_st;
		result_t             expected_levels[$];
		int                  errors;

		function new();
			dev_addr  = DEVICE_ADDR_RST;
			ack_limit = ACK_TIMEOUT_RST;
			two_byte  = 1'b1;
			phase     = PH_IDLE;
			bit_cnt   = '0;
			shreg     = '0;
			wait_cnt  = '0;
			addr_q    = '0;
			data_q    = '0;
			rd_q      = 1'b0;
			rd_byte   = '0;
			last_st   = ST_OK;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DEVICE_ADDR:   dev_addr = data[DEV_W-1:0];
				CFG_ACK_TIMEOUT:   ack_limit = data;
				CFG_TWO_BYTE_ADDR: two_byte = data[0];
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		function bit in_slot();
			return phase >= PH_SLOT_LO && phase < PH_SLOT_HI;
		endfunction

		// line levels driven during the current phase
		function void bus_levels(output logic scl, output logic sda, output logic drv);
			scl = 1'b1;
			sda = 1'b1;
			drv = 1'b1;
			if (in_slot()) begin
				case (phase[1:0])
					SUB_BIT: begin
						scl = bit_cnt[0];
						sda = shreg[7];
					end
					SUB_RELEASE: begin
						scl = 1'b0;
						drv = 1'b0;
					end
					SUB_ACK: drv = 1'b0;
					default: ;
				endcase
			end else if (phase >= PH_STOP) begin
				case (phase[1:0])
					STOP_LOW: begin
						scl = 1'b0;
						sda = 1'b0;
					end
					STOP_SCL: sda = 1'b0;
					default: ;
				endcase
			end else begin
				case (phase)
					PH_S1P, PH_S2P, PH_NACKL: scl = 1'b0;
					PH_S1B, PH_S2B: sda = 1'b0;
					PH_READ: begin
						scl = bit_cnt[0];
						drv = 1'b0;
					end
					default: ;
				endcase
			end
		endfunction

		function void load_slot(logic [2:0] slot, logic [BYTE_W-1:0] value);
			phase = {1'b0, slot, SUB_BIT};
			shreg = value;
			bit_cnt = '0;
		endfunction

		function void stop_with(logic [STATUS_W-1:0] st);
			phase = PH_STOP | {2'b00, st, 2'b00};
		endfunction

		// next byte once the slave has acked
		function void after_ack(logic [2:0] slot);
			case (slot)
				SLOT_DEVW: begin
					if (two_byte) load_slot(SLOT_AHI, addr_q[15:8]);
					else load_slot(SLOT_ALO, addr_q[7:0]);
				end
				SLOT_AHI: load_slot(SLOT_ALO, addr_q[7:0]);
				SLOT_ALO: begin
					if (rd_q) phase = PH_S2P;
					else load_slot(SLOT_DATA, data_q);
				end
				SLOT_DEVR: begin
					phase = PH_READ;
					bit_cnt = '0;
					shreg = '0;
				end
				default: stop_with(ST_OK);
			endcase
		endfunction

		// one bus half-phase; 1 when the stop completes
		function bit advance(logic sda);
			logic [2:0] slot;
			bit ended;
			slot = phase[4:2];
			ended = 1'b0;
			if (in_slot()) begin
				case (phase[1:0])
					SUB_BIT: begin
						if (bit_cnt[0]) shreg = shreg << 1;
						if (bit_cnt == BIT_LAST) begin
							phase = {1'b0, slot, SUB_RELEASE};
							bit_cnt = '0;
						end else bit_cnt++;
					end
					SUB_RELEASE: begin
						wait_cnt = '0;
						phase = {1'b0, slot, SUB_ACK};
					end
					SUB_ACK: begin
						if (!sda) after_ack(slot);
						else if ({1'b0, wait_cnt} + 9'd1 > {1'b0, ack_limit}) stop_with(ST_NO_ACK);
						else wait_cnt++;
					end
					default: phase = PH_IDLE;
				endcase
			end else if (phase >= PH_STOP) begin
				case (phase[1:0])
					STOP_LOW, STOP_SCL: phase = phase + 1'b1;
					STOP_DONE: begin
						last_st = phase[3:2];
						if (last_st == ST_OK && rd_q) rd_byte = shreg;
						phase = PH_IDLE;
						ended = 1'b1;
					end
					default: phase = PH_IDLE;
				endcase
			end else begin
				case (phase)
					PH_S1P, PH_S2P: phase = phase + 1'b1;
					PH_S1A, PH_S2A: begin
						if (!sda) stop_with(ST_BUS_LOW);
						else phase = phase + 1'b1;
					end
					PH_S1B: begin
						if (sda) stop_with(ST_BUS_LOW);
						else load_slot(SLOT_DEVW, {dev_addr, 1'b0});
					end
					PH_S2B: begin
						if (sda) stop_with(ST_BUS_LOW);
						else load_slot(SLOT_DEVR, {dev_addr, 1'b1});
					end
					PH_READ: begin
						if (bit_cnt[0]) shreg = {shreg[6:0], sda};
						if (bit_cnt == BIT_LAST) begin
							phase = PH_NACKL;
							bit_cnt = '0;
						end else bit_cnt++;
					end
					PH_NACKL: phase = PH_NACKH;
					PH_NACKH: stop_with(ST_OK);
					default: phase = PH_IDLE;
				endcase
			end
			return ended;
		endfunction

		// predict the result of an accepted item; 0 when the block ignores it
		function bit take_item(item_t it);
			result_t r;
			logic scl, sdo, drv;
			logic [STATUS_W-1:0] st;
			bit is_req;
			bit worked;
			bus_levels(scl, sdo, drv);
			r = '0;
			st = last_st;
			worked = 1'b1;
			is_req = (it.req_type == REQ_WRITE) || (it.req_type == REQ_READ);
			if (is_req && phase != PH_IDLE) begin
				st = ST_REJECTED;
				worked = 1'b0;
			end else if (is_req) begin
				addr_q = it.word_addr;
				data_q = it.write_data;
				rd_q = (it.req_type == REQ_READ);
				bit_cnt = '0;
				wait_cnt = '0;
				phase = PH_S1P;
			end else if (phase != PH_IDLE) begin
				if (advance(it.sda_in)) begin
					r.done_res = 1'b1;
					st = last_st;
				end
			end
			r.scl_out = scl;
			r.sda_out = sdo;
			r.sda_drive = drv;
			r.busy_res = (phase != PH_IDLE);
			r.status = st;
			r.read_data = rd_byte;
			expected_levels.push_back(r);
			return worked;
		endfunction

		task cmp(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want) report($sformatf("%s is %0h, predicted %0h", name, got, want));
		endtask

		task check(result_t got);
			result_t want;
			if (expected_levels.size() == 0) begin
				report("result with no prediction waiting");
			end else begin
				want = expected_levels.pop_front();
				cmp("scl_out", got.scl_out, want.scl_out);
				cmp("sda_out", got.sda_out, want.sda_out);
				cmp("sda_drive", got.sda_drive, want.sda_drive);
				cmp("busy_res", got.busy_res, want.busy_res);
				cmp("done_res", got.done_res, want.done_res);
				cmp("status", got.status, want.status);
				cmp("read_data", got.read_data, want.read_data);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   slave_absent;
	int   gap_pct;

	i2c_txn_scoreboard sb = new();

	eeb_item_if   item_bus();
	eeb_result_if result_bus();
	eeb_cfg_if    cfg_bus();

	i2c_eeprom_byte_master i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (result_bus),
		.cfg     (cfg_bus)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic item_t item_of(logic [REQ_W-1:0] req, logic [WADDR_W-1:0] addr,
		logic [BYTE_W-1:0] data, logic sda);
		item_t it;
		it.req_type = req;
		it.word_addr = addr;
		it.write_data = data;
		it.sda_in = sda;
		return it;
	endfunction

	// slave model: start levels, acks with some delay or none when absent, random read data
	function automatic logic slave_sda();
		logic sda;
		sda = 1'($urandom_range(0, 1));
		case (sb.phase)
			PH_S1A, PH_S2A: sda = 1'b1;
			PH_S1B, PH_S2B: sda = 1'b0;
			default: begin
				if (sb.in_slot() && sb.phase[1:0] == SUB_ACK)
					sda = slave_absent ? 1'b1 : ($urandom_range(0, 3) == 0);
			end
		endcase
		return sda;
	endfunction

	function automatic item_t make_item(bit noisy);
		item_t it;
		int roll;
		it = item_of(REQ_TICK, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		roll = $urandom_range(0, 99);
		if (sb.phase == PH_IDLE) begin
			if (roll < 40) it.req_type = REQ_WRITE;
			else if (roll < 80) it.req_type = REQ_READ;
			else if (roll < 85) it.req_type = REQ_SPARE;
			if (it.req_type == REQ_WRITE || it.req_type == REQ_READ)
				slave_absent = (sb.ack_limit <= 8'd16) && ($urandom_range(0, 7) == 0);
		end else begin
			it.sda_in = slave_sda();
			if (noisy) begin
				if (roll == 0) it.req_type = REQ_WRITE;
				else if (roll == 1) it.req_type = REQ_READ;
				else if (roll == 2) it.req_type = REQ_SPARE;
				else if (roll >= 97) it.sda_in = ~it.sda_in;
			end
		end
		return it;
	endfunction

	// input side idle burst
	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send(input item_t it, output bit worked);
		item_bus.valid <= 1'b1;
		item_bus.req_type <= it.req_type;
		item_bus.word_addr <= it.word_addr;
		item_bus.write_data <= it.write_data;
		item_bus.sda_in <= it.sda_in;
		do @(posedge clk); while (!item_bus.ready);
		worked = sb.take_item(it);
	endtask

	// finish the running transaction, then wait for every result
	task automatic settle();
		bit worked;
		while (sb.phase != PH_IDLE) begin
			maybe_gap();
			send(make_item(1'b0), worked);
		end
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_levels.size() != 0);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_reg(idx, data);
	endtask

	task automatic program_cfg(logic [DEV_W-1:0] dev, logic [BYTE_W-1:0] limit, logic two);
		put_reg(CFG_DEVICE_ADDR, {1'b0, dev});
		put_reg(CFG_ACK_TIMEOUT, limit);
		put_reg(CFG_TWO_BYTE_ADDR, {7'd0, two});
		cfg_bus.valid <= 1'b0;
	endtask

	// field extremes, idle and spare ticks, start check failures, request while busy
	task automatic directed();
		bit worked;
		send(item_of(REQ_TICK, 16'h0000, 8'h00, 1'b0), worked);
		send(item_of(REQ_TICK, 16'hFFFF, 8'hFF, 1'b1), worked);
		send(item_of(REQ_SPARE, 16'hA5A5, 8'h5A, 1'b0), worked);
		// write aborted by sda low before the start edge
		send(item_of(REQ_WRITE, 16'hFFFF, 8'hFF, 1'b0), worked);
		send(item_of(REQ_TICK, 16'h0000, 8'h00, 1'b1), worked);
		send(item_of(REQ_TICK, 16'h0000, 8'h00, 1'b0), worked);
		settle();
		// read aborted by sda high after the start edge, with a rejected request
		send(item_of(REQ_READ, 16'h0000, 8'h00, 1'b1), worked);
		send(item_of(REQ_WRITE, 16'h1234, 8'hC3, 1'b0), worked);
		send(item_of(REQ_SPARE, 16'h0000, 8'h00, 1'b1), worked);
		send(item_of(REQ_TICK, 16'h0000, 8'h00, 1'b1), worked);
		send(item_of(REQ_TICK, 16'h0000, 8'h00, 1'b1), worked);
		settle();
	endtask

	task automatic run_phase(int n);
		int count;
		bit worked;
		item_t it;
		count = 0;
		while (count < n) begin
			if (count % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
			end
			it = make_item(1'b1);
			maybe_gap();
			send(it, worked);
			if (worked) count++;
		end
		settle();
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		slave_absent = 1'b0;
		gap_pct = 0;
		item_bus.valid = 1'b0;
		item_bus.req_type = REQ_TICK;
		item_bus.word_addr = '0;
		item_bus.write_data = '0;
		item_bus.sda_in = 1'b1;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_DEVICE_ADDR;
		cfg_bus.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		run_phase(PHASE_ITEMS);
		program_cfg(7'd0, 8'd1, 1'b0);
		run_phase(PHASE_ITEMS);
		program_cfg(7'h7F, 8'hFF, 1'b1);
		run_phase(PHASE_ITEMS);
		program_cfg(7'($urandom), 8'($urandom_range(2, 12)), 1'($urandom_range(0, 1)));
		run_phase(PHASE_ITEMS);
		calm = 1'b1;
		program_cfg(7'($urandom), 8'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
		run_phase(PHASE_ITEMS);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_levels.size() != 0) sb.report("predictions left without a result");
		if (sb.errors == 0) begin
			$display("i2c_eeprom_byte_master_tb: done, clean");
		end else begin
			$display("i2c_eeprom_byte_master_tb: done, errors");
		end
		$finish;
	end

	// result side: take, check, stall in bursts
	initial begin
		int stall_left;
		int stall_pct;
		int cyc;
		result_t got;
		result_bus.ready = 1'b0;
		stall_left = 0;
		stall_pct = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				got.scl_out = result_bus.scl_out;
				got.sda_out = result_bus.sda_out;
				got.sda_drive = result_bus.sda_drive;
				got.busy_res = result_bus.busy_res;
				got.done_res = result_bus.done_res;
				got.status = result_bus.status;
				got.read_data = result_bus.read_data;
				sb.check(got);
			end
			if (cyc % 64 == 0) stall_pct = 10 * $urandom_range(0, 3);
			cyc++;
			if (!arst_n) begin
				result_bus.ready <= 1'b0;
			end else if (!calm && stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 7);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("i2c_eeprom_byte_master_tb: done, errors");
		$finish;
	end

endmodule
